[src/zero_run_signed_varint_encoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the zero-run signed varint encoder
// Concurrent assertion wrappers that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_SIGNED_VARINT_ENCODER_UNIT_MACROS_SVH
`define ZERO_RUN_SIGNED_VARINT_ENCODER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ZRSV_ASSERT_CLK(label, ck, rstn, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
`define ZRSV_ASSERT(label, prop, msg) \
	`ZRSV_ASSERT_CLK(label, clk, arst_n, prop, msg)
`else
`define ZRSV_ASSERT_CLK(label, ck, rstn, prop, msg)
`define ZRSV_ASSERT(label, prop, msg)
`endif
`endif

[src/zrsv_pkg.sv]
// ----------------------------------------------------------------------------
// zrsv_pkg
// Shared widths and types of the zero-run signed varint encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package zrsv_pkg;

	parameter int POSITION_WIDTH = 48;
	parameter int RUN_W          = 32;
	// Encoded run value is count * 2, a positive number of RUN_W + 1 bits plus sign.
	parameter int VAL_W          = (POSITION_WIDTH + 1 > RUN_W + 2) ?
	                               POSITION_WIDTH + 1 : RUN_W + 2;
	parameter int QUEUE_DEPTH    = 2;
	parameter int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	parameter int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	typedef logic [RUN_W-1:0]                 run_cnt_t;
	typedef logic signed [POSITION_WIDTH-1:0] position_t;
	typedef logic signed [VAL_W-1:0]          enc_val_t;

	// One classified item: an optional run to encode, then an optional word.
	typedef struct packed {
		logic      has_run;
		run_cnt_t  run_cnt;
		logic      has_word;
		position_t word;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

[src/zrsv_queue.sv]
// ----------------------------------------------------------------------------
// zrsv_queue
// Short job queue between the classifying front and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "zero_run_signed_varint_encoder_unit_macros.svh"

module zrsv_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire zrsv_pkg::job_t         push_job,
	input  wire logic                   pop,
	output zrsv_pkg::job_t              head_job,
	output zrsv_pkg::queue_status_t     status
);

	zrsv_pkg::job_t                    entry_q [zrsv_pkg::QUEUE_DEPTH];
	logic [zrsv_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [zrsv_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [zrsv_pkg::QCNT_W-1:0]       count_q;

	function automatic logic [zrsv_pkg::QPTR_W-1:0] ptr_next(
		input logic [zrsv_pkg::QPTR_W-1:0] p);
		if (p == zrsv_pkg::QPTR_W'(zrsv_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign head_job     = entry_q[rd_ptr_q];
	assign status.full  = (count_q == zrsv_pkg::QCNT_W'(zrsv_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ZRSV_ASSERT(a_no_push_when_full, push |-> !status.full, "push into a full queue")
	`ZRSV_ASSERT(a_no_pop_when_empty, pop |-> !status.empty, "pop from an empty queue")
	`ZRSV_ASSERT(a_count_in_range, count_q <= zrsv_pkg::QCNT_W'(zrsv_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

[src/zrsv_front.sv]
// ----------------------------------------------------------------------------
// zrsv_front
// Accepts position words, tracks the zero run and the last negative word,
// and turns each item that has a run or a word to write into a job for the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module zrsv_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire zrsv_pkg::position_t    position,
	input  wire logic                   stream_end,
	input  wire zrsv_pkg::queue_status_t q_status,
	output logic                        push,
	output zrsv_pkg::job_t              push_job
);

	zrsv_pkg::run_cnt_t  run_count_q;
	zrsv_pkg::position_t prev_neg_q;

	logic               accept;
	logic               is_zero;
	logic               is_neg;
	logic               is_dup;
	zrsv_pkg::run_cnt_t run_inc;

	assign item_stall = q_status.full;
	assign accept     = item_valid && !item_stall;
	assign is_zero    = (position == '0);
	assign is_neg     = position[zrsv_pkg::POSITION_WIDTH-1];
	assign is_dup     = is_neg && (position == prev_neg_q);
	// The run count saturates rather than wrapping.
	assign run_inc    = (run_count_q == '1) ? run_count_q : run_count_q + 1'b1;

	always_comb begin
		push_job.has_run  = is_zero ? stream_end : (run_count_q != '0);
		push_job.run_cnt  = is_zero ? run_inc : run_count_q;
		push_job.has_word = !is_zero;
		push_job.word     = is_dup ? '0 : position;
	end

	assign push = accept && (push_job.has_run || push_job.has_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			prev_neg_q  <= zrsv_pkg::POSITION_WIDTH'(1);
		end else if (accept) begin
			if (stream_end) begin
				run_count_q <= '0;
				prev_neg_q  <= zrsv_pkg::POSITION_WIDTH'(1);
			end else if (is_zero) begin
				run_count_q <= run_inc;
			end else begin
				run_count_q <= '0;
				if (is_neg && !is_dup) begin
					prev_neg_q <= position;
				end
			end
		end
	end

endmodule

`default_nettype wire

[src/zrsv_back.sv]
// ----------------------------------------------------------------------------
// zrsv_back
// Serializes queued jobs into signed LEB128 bytes, seven bits per cycle while
// the receiver does not stall, into an output register that holds while it stalls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "zero_run_signed_varint_encoder_unit_macros.svh"

module zrsv_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire zrsv_pkg::job_t          head_job,
	input  wire zrsv_pkg::queue_status_t q_status,
	output logic                         pop,
	output logic                         byte_valid,
	input  wire logic                    byte_stall,
	output logic [7:0]                   out_byte,
	output logic                         last_of_item
);

	logic               cur_valid_q;
	zrsv_pkg::enc_val_t cur_val_q;
	logic               word_pend_q;
	zrsv_pkg::enc_val_t word_val_q;

	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               last_q;

	logic               out_free;
	logic               step;
	zrsv_pkg::enc_val_t shifted;
	logic               done;
	logic               load;
	zrsv_pkg::enc_val_t head_run_val;
	zrsv_pkg::enc_val_t head_word_val;

	assign out_free = !out_valid_q || !byte_stall;
	assign step     = cur_valid_q && out_free;
	assign shifted  = cur_val_q >>> 7;
	// The value is finished once the remaining bits are pure sign matching bit 6.
	assign done     = cur_val_q[6] ? (shifted == '1) : (shifted == '0);
	assign load     = (!cur_valid_q || (step && done && !word_pend_q)) && !q_status.empty;
	assign pop      = load;

	assign head_run_val  = zrsv_pkg::enc_val_t'({head_job.run_cnt, 1'b0});
	assign head_word_val = zrsv_pkg::VAL_W'(signed'({head_job.word, 1'b1}));

	always_ff @(posedge clk) begin
		if (load) begin
			cur_val_q  <= head_job.has_run ? head_run_val : head_word_val;
			word_val_q <= head_word_val;
		end else if (step) begin
			cur_val_q <= (done && word_pend_q) ? word_val_q : shifted;
		end
		if (step) begin
			out_byte_q <= {!done, cur_val_q[6:0]};
			last_q     <= done && !word_pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			word_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
				word_pend_q <= head_job.has_run && head_job.has_word;
			end else if (step && done) begin
				if (word_pend_q) begin
					word_pend_q <= 1'b0;
				end else begin
					cur_valid_q <= 1'b0;
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign byte_valid   = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_item = last_q;

	`ZRSV_ASSERT(a_last_ends_value, out_valid_q && last_q |-> !out_byte_q[7], "item ends on a continuation byte")
	`ZRSV_ASSERT(a_more_keeps_busy, step && !done |=> cur_valid_q, "serializer dropped an unfinished value")
	`ZRSV_ASSERT(a_hold_when_blocked, cur_valid_q && !out_free |=> $stable(cur_val_q), "value moved while output blocked")

endmodule

`default_nettype wire

[src/zero_run_signed_varint_encoder_unit.sv]
// ----------------------------------------------------------------------------
// zero_run_signed_varint_encoder_unit
// Encodes signed position words as zero-run signed LEB128 bytes.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall): one position word and its
// stream_end flag per transfer. Zero words are only counted; a pending run is
// written as one value when a nonzero word arrives or the stream ends.
// Output channel (byte_valid / byte_stall): one encoded byte per transfer,
// with last_of_item set on the final byte that an input item caused.
// With the serializer idle, the first byte of an item passes through a queue
// entry, the serializer's value register and the output register.
// Throughput: the serializer writes one byte per cycle while the receiver does
// not stall, with no gap between queued items; an item has 1 to 12 bytes (typical
// words need one or two), and a zero word that does not end the stream writes
// no byte. A two-entry job queue lets the input keep moving while bytes of
// earlier items are still out.
// Reset clears the run count, sets the last negative word to +1, and empties
// the queue and output register. While the receiver stalls, the output byte
// holds; once the queue fills, item_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_run_signed_varint_encoder_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic signed [zrsv_pkg::POSITION_WIDTH-1:0] position,
	input  wire logic                 stream_end,
	output logic                      byte_valid,
	input  wire logic                 byte_stall,
	output logic [7:0]                out_byte,
	output logic                      last_of_item
);

	logic                    push;
	zrsv_pkg::job_t          push_job;
	logic                    pop;
	zrsv_pkg::job_t          head_job;
	zrsv_pkg::queue_status_t q_status;

	zrsv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.position   (position),
		.stream_end (stream_end),
		.q_status   (q_status),
		.push       (push),
		.push_job   (push_job)
	);

	zrsv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_status)
	);

	zrsv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.q_status     (q_status),
		.pop          (pop),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.out_byte     (out_byte),
		.last_of_item (last_of_item)
	);

endmodule

`default_nettype wire
